>>> hdl/jlg_pkg.sv
// ----------------------------------------------------------------------------
// jlg_pkg
// shared types and constants of the joint limit guard
// ----------------------------------------------------------------------------
package jlg_pkg;

	// control mode codes
	localparam logic [2:0] MODE_OTHER   = 3'd0;
	localparam logic [2:0] MODE_POS     = 3'd1;
	localparam logic [2:0] MODE_OPEN    = 3'd2;
	localparam logic [2:0] MODE_TRQ     = 3'd3;
	localparam logic [2:0] MODE_IMP_POS = 3'd4;
	localparam logic [2:0] MODE_IMP_VEL = 3'd5;

	// default queue depths
	localparam int unsigned MID_QUEUE_DEPTH = 2;
	localparam int unsigned RES_QUEUE_DEPTH = 2;

	// classified sample, front to back
	typedef struct packed {
		logic [1:0]         axis;
		logic [2:0]         mode;
		logic signed [31:0] desired;
		logic signed [31:0] pwm;
		logic               restart;
		logic               clr_int;
		logic               clr_off;
		logic               use_spring;
		logic signed [31:0] diff;
		logic signed [15:0] gain;
		logic [3:0]         gain_shift;
	} work_t;

	// finished result beat
	typedef struct packed {
		logic [1:0]         axis;
		logic [2:0]         mode;
		logic signed [31:0] desired;
		logic signed [31:0] pwm;
		logic               restart;
		logic               clr_int;
		logic               clr_off;
	} res_t;

endpackage

>>> hdl/jlg_fifo.sv
// ----------------------------------------------------------------------------
// jlg_fifo
// small register queue used between the guard stages and for the results
// ----------------------------------------------------------------------------
module jlg_fifo #(
	parameter int unsigned DEPTH = jlg_pkg::MID_QUEUE_DEPTH,
	parameter type item_t = jlg_pkg::work_t
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t din,
	input  logic  pop,
	output logic  empty,
	output item_t dout
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// occupancy bookkeeping
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count missed a pop");

endmodule

>>> hdl/jlg_front.sv
// ----------------------------------------------------------------------------
// jlg_front
// takes samples, runs the limit compares and registers the classified beat
// ----------------------------------------------------------------------------
module jlg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          axis,
	input  logic [2:0]          mode,
	input  logic signed [31:0]  position,
	input  logic signed [31:0]  desired,
	input  logic signed [31:0]  pwm_in,
	input  logic signed [31:0]  max_limit,
	input  logic signed [31:0]  min_limit,
	input  logic signed [15:0]  gain,
	input  logic [3:0]          gain_shift,
	input  logic signed [15:0]  band,
	output logic                valid_s1,
	input  logic                ready,
	output jlg_pkg::work_t      work_s1
);

	logic signed [31:0] band_ext;
	logic signed [31:0] hi_in;
	logic signed [31:0] lo_in;
	logic signed [31:0] hi_lim;
	logic signed [31:0] lo_lim;
	logic               band_pos;
	logic               outside;
	logic               hi_take;
	logic               lo_take;
	logic signed [31:0] hi_val;
	logic signed [31:0] lo_val;
	logic signed [31:0] des_mid;
	logic signed [31:0] des_new;
	logic               agree;
	logic               t_hi;
	logic               t_lo;
	logic               take;
	jlg_pkg::work_t     work;

	assign band_ext = {{16{band[15]}}, band};
	assign hi_in    = max_limit - band_ext;
	assign lo_in    = min_limit + band_ext;
	assign hi_lim   = max_limit + band_ext;
	assign lo_lim   = min_limit - band_ext;
	assign band_pos = !band[15] && (band != 16'sd0);
	assign outside  = (position > hi_in) || (position < lo_in);

	// upper clamp first, lower clamp sees the updated set point
	assign hi_take = (band_pos ? (position > hi_in) : (position > hi_lim)) && (desired > hi_in);
	assign hi_val  = band_pos ? hi_in : max_limit;
	assign des_mid = hi_take ? hi_val : desired;
	assign lo_take = (band_pos ? (position < lo_in) : (position < lo_lim)) && (des_mid < lo_in);
	assign lo_val  = band_pos ? lo_in : min_limit;
	assign des_new = lo_take ? lo_val : des_mid;

	// spring replacement for torque style modes
	assign agree = (gain > 16'sd0) == (pwm_in > 32'sd0);
	assign t_hi  = (position > max_limit) && agree;
	assign t_lo  = (position < min_limit) && !agree;

	always_comb begin
		work            = '0;
		work.axis       = axis;
		work.mode       = mode;
		work.desired    = desired;
		work.pwm        = pwm_in;
		work.gain       = gain;
		work.gain_shift = gain_shift;
		work.diff       = t_lo ? (min_limit - position) : (max_limit - position);
		case (mode)
			jlg_pkg::MODE_POS, jlg_pkg::MODE_OPEN: begin
				if (outside) begin
					work.mode    = jlg_pkg::MODE_POS;
					work.clr_off = 1'b1;
					work.desired = des_new;
					work.restart = hi_take || lo_take;
					work.clr_int = hi_take || lo_take;
				end
			end
			jlg_pkg::MODE_TRQ, jlg_pkg::MODE_IMP_POS, jlg_pkg::MODE_IMP_VEL: begin
				work.use_spring = t_hi || t_lo;
				work.clr_int    = t_hi || t_lo;
			end
			default: begin
				work.mode = mode;
			end
		endcase
	end

	assign full = valid_s1 && !ready;
	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || ready) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_s1 <= work;
		end
	end

endmodule

>>> hdl/jlg_back.sv
// ----------------------------------------------------------------------------
// jlg_back
// gain multiply, shift toward zero and final drive selection
// ----------------------------------------------------------------------------
module jlg_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  jlg_pkg::work_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output jlg_pkg::res_t  out_item
);

	logic               valid_s2;
	jlg_pkg::work_t     work_s2;
	logic [31:0]        prod_s2;
	logic signed [47:0] prod_full;
	logic [31:0]        prod_neg;
	logic [31:0]        mag;
	logic [31:0]        spring;

	assign prod_full = 48'(in_item.diff) * 48'(in_item.gain);
	assign in_ready  = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_s2 <= in_item;
			prod_s2 <= prod_full[31:0];
		end
	end

	// negative products shift as a magnitude so the result truncates toward zero
	assign prod_neg = 32'd0 - prod_s2;
	assign mag      = prod_neg >> work_s2.gain_shift;
	assign spring   = prod_s2[31] ? (32'd0 - mag) : (prod_s2 >> work_s2.gain_shift);

	assign out_valid        = valid_s2;
	assign out_item.axis    = work_s2.axis;
	assign out_item.mode    = work_s2.mode;
	assign out_item.desired = work_s2.desired;
	assign out_item.pwm     = work_s2.use_spring ? $signed(spring) : work_s2.pwm;
	assign out_item.restart = work_s2.restart;
	assign out_item.clr_int = work_s2.clr_int;
	assign out_item.clr_off = work_s2.clr_off;

endmodule

>>> hdl/joint_limit_guard.sv
// ----------------------------------------------------------------------------
// joint_limit_guard
// soft-limit guard for one joint sample per beat
// ----------------------------------------------------------------------------
// The guard takes one axis sample per clock while full is low and returns one
// result beat per sample, in order. A sample is taken when push is high and
// full is low; the oldest result sits on the result ports while empty is low
// and leaves on pop. A sample passes the front register with the limit
// compares, the middle queue, the back register with the gain multiply and
// the result queue; the back part sustains one sample per cycle while no
// stage stalls. The front and back parts are joined by a small queue, and a
// second queue holds finished results, so a stalled consumer does not stop
// intake until both queues have filled. The guard band register is written
// through its own valid/ready channel, which is always ready; write it only
// while no sample is in flight.
// ----------------------------------------------------------------------------
module joint_limit_guard #(
	parameter int unsigned MID_DEPTH = jlg_pkg::MID_QUEUE_DEPTH,
	parameter int unsigned RES_DEPTH = jlg_pkg::RES_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample side
	input  logic               push,
	output logic               full,
	input  logic [1:0]         axis,
	input  logic [2:0]         mode,
	input  logic signed [31:0] position,
	input  logic signed [31:0] desired,
	input  logic signed [31:0] pwm_in,
	input  logic signed [31:0] max_limit,
	input  logic signed [31:0] min_limit,
	input  logic signed [15:0] gain,
	input  logic [3:0]         gain_shift,
	// result side
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         axis_out,
	output logic [2:0]         mode_out,
	output logic signed [31:0] desired_out,
	output logic signed [31:0] pwm_out,
	output logic               restart_trajectory,
	output logic               clear_integral,
	output logic               clear_offset,
	// guard band register
	input  logic               band_valid,
	output logic               band_ready,
	input  logic signed [15:0] band
);

	logic signed [15:0] band_q;
	logic               valid_s1;
	logic               mid_full;
	logic               mid_empty;
	logic               back_ready;
	logic               back_valid;
	logic               res_full;
	jlg_pkg::work_t     work_s1;
	jlg_pkg::work_t     mid_item;
	jlg_pkg::res_t      back_item;
	jlg_pkg::res_t      res_item;

	// band register, always ready for a beat
	assign band_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
		end else if (band_valid) begin
			band_q <= band;
		end
	end

	// front: compares, clamping and classification
	jlg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.axis       (axis),
		.mode       (mode),
		.position   (position),
		.desired    (desired),
		.pwm_in     (pwm_in),
		.max_limit  (max_limit),
		.min_limit  (min_limit),
		.gain       (gain),
		.gain_shift (gain_shift),
		.band       (band_q),
		.valid_s1   (valid_s1),
		.ready      (!mid_full),
		.work_s1    (work_s1)
	);

	// decoupling queue between front and back
	jlg_fifo #(
		.DEPTH  (MID_DEPTH),
		.item_t (jlg_pkg::work_t)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s1),
		.full   (mid_full),
		.din    (work_s1),
		.pop    (back_ready),
		.empty  (mid_empty),
		.dout   (mid_item)
	);

	// back: spring term and drive selection
	jlg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (!mid_empty),
		.in_ready  (back_ready),
		.in_item   (mid_item),
		.out_valid (back_valid),
		.out_ready (!res_full),
		.out_item  (back_item)
	);

	// result queue, head drives the result ports
	jlg_fifo #(
		.DEPTH  (RES_DEPTH),
		.item_t (jlg_pkg::res_t)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_valid),
		.full   (res_full),
		.din    (back_item),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_item)
	);

	assign axis_out           = res_item.axis;
	assign mode_out           = res_item.mode;
	assign desired_out        = res_item.desired;
	assign pwm_out            = res_item.pwm;
	assign restart_trajectory = res_item.restart;
	assign clear_integral     = res_item.clr_int;
	assign clear_offset       = res_item.clr_off;

	// a clamped set point always clears the integral
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && restart_trajectory) |-> clear_integral)
		else $error("restart without integral clear");

	// a clamp only happens once the position is outside the band
	a_restart_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && restart_trajectory) |-> clear_offset)
		else $error("restart without offset clear");

	// open loop is forced to position mode when outside
	a_open_forced: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && clear_offset) |-> (mode_out == jlg_pkg::MODE_POS))
		else $error("offset cleared outside position mode");

endmodule

>>> verif/joint_limit_guard_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_limit_guard_tb
// self-checking bench for the joint soft-limit guard
// ----------------------------------------------------------------------------
// A short table of hand-picked samples comes first: pass-through modes, the
// position clamps on both sides with positive and non-positive bands, the
// spring replacement in torque and impedance modes, wrap-around and the most
// negative product. Rows whose result is obvious carry it typed in; the rest
// are checked against a predictor of the guard. Random samples follow in
// phases, each under its own guard band, with idle gaps on both queue sides,
// one long consumer hold-off that backs the block up, and a mid-phase drain.
// ----------------------------------------------------------------------------
module joint_limit_guard_tb;

	// modes with no guard action
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
	localparam logic signed [15:0] BAND_MAX = 16'sh7FFF;
	localparam logic signed [15:0] BAND_MIN = 16'sh8000;

	localparam int unsigned CYCLE_LIMIT   = 400_000;
	localparam int          PHASES        = 10;
	localparam int          PHASE_SAMPLES = 130;
	localparam int          HOLD_CYCLES   = 150;

	// one joint sample as offered on the input side
	typedef struct packed {
		logic [1:0]         axis;
		logic [2:0]         mode;
		logic signed [31:0] position;
		logic signed [31:0] desired;
		logic signed [31:0] pwm_in;
		logic signed [31:0] max_limit;
		logic signed [31:0] min_limit;
		logic signed [15:0] gain;
		logic [3:0]         gain_shift;
	} sample_t;

	// row of the directed table; known rows carry their result typed in
	typedef struct packed {
		logic signed [15:0] band;
		logic               known;
		sample_t            stim;
		jlg_pkg::res_t      want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               push = 1'b0;
	logic               full;
	logic [1:0]         axis = '0;
	logic [2:0]         mode = jlg_pkg::MODE_OTHER;
	logic signed [31:0] position = '0;
	logic signed [31:0] desired = '0;
	logic signed [31:0] pwm_in = '0;
	logic signed [31:0] max_limit = '0;
	logic signed [31:0] min_limit = '0;
	logic signed [15:0] gain = '0;
	logic [3:0]         gain_shift = '0;

	logic               empty;
	logic               pop = 1'b0;
	logic [1:0]         axis_out;
	logic [2:0]         mode_out;
	logic signed [31:0] desired_out;
	logic signed [31:0] pwm_out;
	logic               restart_trajectory;
	logic               clear_integral;
	logic               clear_offset;

	logic               band_valid = 1'b0;
	logic               band_ready;
	logic signed [15:0] band = '0;

	// bench-side copy of the guard band, follows every accepted write
	logic signed [15:0] band_now = '0;
	// results still owed by the block, oldest first
	jlg_pkg::res_t      guard_due[$];
	int                 faults = 0;
	int unsigned        cycle_count = 0;
	// consumer pacing, set by the stimulus, obeyed by the pop process
	bit                 rx_eager = 1'b0;
	int                 hold_ask = 0;

	joint_limit_guard dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.axis              (axis),
		.mode              (mode),
		.position          (position),
		.desired           (desired),
		.pwm_in            (pwm_in),
		.max_limit         (max_limit),
		.min_limit         (min_limit),
		.gain              (gain),
		.gain_shift        (gain_shift),
		.empty             (empty),
		.pop               (pop),
		.axis_out          (axis_out),
		.mode_out          (mode_out),
		.desired_out       (desired_out),
		.pwm_out           (pwm_out),
		.restart_trajectory(restart_trajectory),
		.clear_integral    (clear_integral),
		.clear_offset      (clear_offset),
		.band_valid        (band_valid),
		.band_ready        (band_ready),
		.band              (band)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic sample_t sample_of(logic [1:0] ax, logic [2:0] md,
			logic signed [31:0] pos, logic signed [31:0] des, logic signed [31:0] drv,
			logic signed [31:0] hi, logic signed [31:0] lo, logic signed [15:0] g,
			logic [3:0] sh);
		sample_t s;
		s = {ax, md, pos, des, drv, hi, lo, g, sh};
		return s;
	endfunction

	function automatic jlg_pkg::res_t result_of(logic [1:0] ax, logic [2:0] md,
			logic signed [31:0] des, logic signed [31:0] drv, logic rs, logic ci,
			logic co);
		jlg_pkg::res_t r;
		r = {ax, md, des, drv, rs, ci, co};
		return r;
	endfunction

	// (limit - position) * gain, wrapped to 32 bits, then shifted with the
	// magnitude truncated toward zero; the most negative product wraps back
	function automatic logic signed [31:0] spring_term(logic signed [31:0] lim,
			logic signed [31:0] pos, logic signed [31:0] g32, logic [3:0] sh);
		logic [31:0] prod;
		logic [31:0] mag;
		prod = (lim - pos) * g32;
		if (prod[31]) begin
			mag = (32'd0 - prod) >> sh;
			return 32'd0 - mag;
		end
		return prod >> sh;
	endfunction

	// result the guard owes for one sample under the given band
	function automatic jlg_pkg::res_t guard_predict(sample_t s, logic signed [15:0] bnd);
		jlg_pkg::res_t      r;
		logic signed [31:0] b32;
		logic signed [31:0] g32;
		logic signed [31:0] hi_in;
		logic signed [31:0] lo_in;
		logic               agree;
		b32   = 32'(bnd);
		g32   = 32'(s.gain);
		hi_in = s.max_limit - b32;
		lo_in = s.min_limit + b32;
		r     = result_of(s.axis, s.mode, s.desired, s.pwm_in, 1'b0, 1'b0, 1'b0);
		if (s.mode == jlg_pkg::MODE_POS || s.mode == jlg_pkg::MODE_OPEN) begin
			if (s.position > hi_in || s.position < lo_in) begin
				r.mode    = jlg_pkg::MODE_POS;
				r.clr_off = 1'b1;
				if (b32 > 0) begin
					// clamp to the shrunk band, lower side sees the upper clamp
					if (s.position > hi_in && r.desired > hi_in) begin
						r.desired = hi_in;
						r.restart = 1'b1;
						r.clr_int = 1'b1;
					end
					if (s.position < lo_in && r.desired < lo_in) begin
						r.desired = lo_in;
						r.restart = 1'b1;
						r.clr_int = 1'b1;
					end
				end else begin
					// zero or negative band clamps to the limit itself
					if (s.position > s.max_limit + b32 && r.desired > hi_in) begin
						r.desired = s.max_limit;
						r.restart = 1'b1;
						r.clr_int = 1'b1;
					end
					if (s.position < s.min_limit - b32 && r.desired < lo_in) begin
						r.desired = s.min_limit;
						r.restart = 1'b1;
						r.clr_int = 1'b1;
					end
				end
			end
		end else if (s.mode == jlg_pkg::MODE_TRQ || s.mode == jlg_pkg::MODE_IMP_POS ||
				s.mode == jlg_pkg::MODE_IMP_VEL) begin
			// signs are taken from the incoming drive, before any replacement
			agree = (s.gain > 0) == (s.pwm_in > 0);
			if (s.position > s.max_limit && agree) begin
				r.pwm     = spring_term(s.max_limit, s.position, g32, s.gain_shift);
				r.clr_int = 1'b1;
			end
			if (s.position < s.min_limit && !agree) begin
				r.pwm     = spring_term(s.min_limit, s.position, g32, s.gain_shift);
				r.clr_int = 1'b1;
			end
		end
		return r;
	endfunction

	// mostly no gap, sometimes a few cycles, now and then a long one
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return $urandom_range(12, 40);
		if (pick <= 4)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	// random sample: mostly clustered around a limit so the clamps and the
	// spring fire, the rest full-width noise to toggle every bit
	function automatic sample_t rand_sample(logic signed [15:0] bnd);
		sample_t            s;
		int                 spread;
		logic signed [31:0] base;
		logic signed [31:0] anchor;
		s.axis       = 2'($urandom_range(0, 3));
		s.mode       = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 5));
		s.pwm_in     = ($urandom_range(0, 1) != 0) ? $urandom()
			: int'($urandom_range(0, 2000)) - 1000;
		s.gain       = ($urandom_range(0, 2) == 0) ? 16'($urandom())
			: 16'(int'($urandom_range(0, 64)) - 32);
		s.gain_shift = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 4) == 0) begin
			s.position  = $urandom();
			s.desired   = $urandom();
			s.max_limit = $urandom();
			s.min_limit = $urandom();
		end else begin
			spread      = 32 + ((bnd < 0) ? -int'(bnd) : int'(bnd));
			// an occasional far-off base walks the sums across the wrap point
			base        = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
			s.min_limit = base + (int'($urandom_range(0, 4000)) - 2000);
			s.max_limit = s.min_limit + int'($urandom_range(0, 4000));
			anchor      = ($urandom_range(0, 1) != 0) ? s.max_limit : s.min_limit;
			s.position  = anchor + (int'($urandom_range(0, 4 * spread)) - 2 * spread);
			s.desired   = anchor + (int'($urandom_range(0, 4 * spread)) - 2 * spread);
		end
		return s;
	endfunction

	// hold the sample on the ports until the block takes it, then book its result
	task automatic offer_sample(sample_t s, int gap, logic known, jlg_pkg::res_t want);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		axis       <= s.axis;
		mode       <= s.mode;
		position   <= s.position;
		desired    <= s.desired;
		pwm_in     <= s.pwm_in;
		max_limit  <= s.max_limit;
		min_limit  <= s.min_limit;
		gain       <= s.gain;
		gain_shift <= s.gain_shift;
		push       <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		guard_due.push_back(known ? want : guard_predict(s, band_now));
	endtask

	// stop offering and wait until every owed result has been popped
	task automatic settle_block();
		push <= 1'b0;
		do
			@(posedge clk);
		while (guard_due.size() != 0);
	endtask

	task automatic write_band(logic signed [15:0] value);
		band       <= value;
		band_valid <= 1'b1;
		@(posedge clk);
		while (!band_ready)
			@(posedge clk);
		band_valid <= 1'b0;
		band_now = value;
	endtask

	task automatic check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			faults++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// consumer: random pop gaps, eager stretches, and the long hold-off on request
	initial begin : pop_side
		int stall;
		int hold_left;
		int hold_seen;
		stall     = 0;
		hold_left = 0;
		hold_seen = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop   <= 1'b1;
				stall = rx_eager ? 0 : idle_len();
			end
		end
	end

	// every popped beat against the oldest owed result
	always @(posedge clk) begin
		jlg_pkg::res_t due;
		if (arst_n && pop && !empty) begin
			if (guard_due.size() == 0) begin
				faults++;
				$error("result beat with nothing owed: axis %0d mode %0d", axis_out,
					mode_out);
			end else begin
				due = guard_due.pop_front();
				check_field("axis_out", 32'(due.axis), 32'(axis_out));
				check_field("mode_out", 32'(due.mode), 32'(mode_out));
				check_field("desired_out", due.desired, desired_out);
				check_field("pwm_out", due.pwm, pwm_out);
				check_field("restart_trajectory", 32'(due.restart),
					32'(restart_trajectory));
				check_field("clear_integral", 32'(due.clr_int), 32'(clear_integral));
				check_field("clear_offset", 32'(due.clr_off), 32'(clear_offset));
			end
		end
	end

	initial begin : stimulus
		plan_row_t          plan[$];
		jlg_pkg::res_t      no_res;
		logic signed [15:0] band_plan[PHASES];
		bit                 tx_eager;
		no_res = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// band at reset: pass-through modes with extreme fields
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd0, jlg_pkg::MODE_OTHER, S32_MAX, S32_MIN, S32_MIN, 0, 0,
				-32768, 15),
			result_of(2'd0, jlg_pkg::MODE_OTHER, S32_MIN, S32_MIN, 1'b0, 1'b0, 1'b0)});
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd1, MODE_SPARE6, 0, -1, S32_MAX, -5, 5, 32767, 0),
			result_of(2'd1, MODE_SPARE6, -1, S32_MAX, 1'b0, 1'b0, 1'b0)});
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd3, MODE_SPARE7, S32_MIN, S32_MAX, 1, S32_MIN, S32_MAX, 1, 7),
			result_of(2'd3, MODE_SPARE7, S32_MAX, 1, 1'b0, 1'b0, 1'b0)});
		// position mode inside the limits, then past the top with desired beyond
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd2, jlg_pkg::MODE_POS, 0, 50, 7, 100, -100, 3, 0),
			result_of(2'd2, jlg_pkg::MODE_POS, 50, 7, 1'b0, 1'b0, 1'b0)});
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd2, jlg_pkg::MODE_POS, 200, 150, 7, 100, -100, 3, 0),
			result_of(2'd2, jlg_pkg::MODE_POS, 100, 7, 1'b1, 1'b1, 1'b1)});
		// open loop: inside stays, outside falls back to position mode
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd1, jlg_pkg::MODE_OPEN, 0, 500, -3, 100, -100, 3, 0),
			result_of(2'd1, jlg_pkg::MODE_OPEN, 500, -3, 1'b0, 1'b0, 1'b0)});
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd1, jlg_pkg::MODE_OPEN, -200, -50, -3, 100, -100, 3, 0),
			result_of(2'd1, jlg_pkg::MODE_POS, -50, -3, 1'b0, 1'b0, 1'b1)});
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd1, jlg_pkg::MODE_OPEN, -200, -300, -3, 100, -100, 3, 0),
			result_of(2'd1, jlg_pkg::MODE_POS, -100, -3, 1'b1, 1'b1, 1'b1)});
		// torque spring past the top, past the bottom, and a drive left alone
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd0, jlg_pkg::MODE_TRQ, 150, 9, 10, 100, -100, 2, 1),
			result_of(2'd0, jlg_pkg::MODE_TRQ, 9, -50, 1'b0, 1'b1, 1'b0)});
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd0, jlg_pkg::MODE_TRQ, -150, 9, -10, 100, -100, 2, 2),
			result_of(2'd0, jlg_pkg::MODE_TRQ, 9, 25, 1'b0, 1'b1, 1'b0)});
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd3, jlg_pkg::MODE_IMP_POS, 150, 9, -10, 100, -100, 2, 0),
			result_of(2'd3, jlg_pkg::MODE_IMP_POS, 9, -10, 1'b0, 1'b0, 1'b0)});
		// zero gain and zero drive both count as not positive, so they agree
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd3, jlg_pkg::MODE_IMP_VEL, 150, 9, 0, 100, -100, 0, 5),
			result_of(2'd3, jlg_pkg::MODE_IMP_VEL, 9, 0, 1'b0, 1'b1, 1'b0)});
		// most negative product, unshifted and shifted
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd0, jlg_pkg::MODE_TRQ, 0, 4, 1, 100000, 65536, -32768, 0),
			result_of(2'd0, jlg_pkg::MODE_TRQ, 4, S32_MIN, 1'b0, 1'b1, 1'b0)});
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd0, jlg_pkg::MODE_TRQ, 0, 4, 1, 100000, 65536, -32768, 4),
			result_of(2'd0, jlg_pkg::MODE_TRQ, 4, 32'shF800_0000, 1'b0, 1'b1, 1'b0)});
		// limit difference wraps to one; minus one shifted truncates to zero
		plan.push_back({16'sd0, 1'b1,
			sample_of(2'd2, jlg_pkg::MODE_TRQ, S32_MAX, 4, -5, S32_MIN, S32_MIN, -1, 3),
			result_of(2'd2, jlg_pkg::MODE_TRQ, 4, 0, 1'b0, 1'b1, 1'b0)});
		plan.push_back({16'sd0, 1'b0,
			sample_of(2'd1, jlg_pkg::MODE_IMP_POS, -1000000, 4, -1, 5, 0, 32767, 15),
			no_res});
		// widest positive band: both clamps fire, the lower one wins
		plan.push_back({BAND_MAX, 1'b0,
			sample_of(2'd0, jlg_pkg::MODE_POS, 0, 0, 11, 1000, -1000, 1, 0), no_res});
		plan.push_back({BAND_MAX, 1'b0,
			sample_of(2'd1, jlg_pkg::MODE_OPEN, S32_MAX, S32_MAX, 11, S32_MAX, S32_MIN,
				1, 0),
			no_res});
		// most negative band: clamps go to the limits themselves
		plan.push_back({BAND_MIN, 1'b0,
			sample_of(2'd2, jlg_pkg::MODE_POS, 40000, 50000, 12, 0, 0, 1, 0), no_res});
		plan.push_back({BAND_MIN, 1'b0,
			sample_of(2'd2, jlg_pkg::MODE_POS, -40000, -40000, 12, 0, 0, 1, 0), no_res});
		plan.push_back({BAND_MIN, 1'b0,
			sample_of(2'd3, jlg_pkg::MODE_OPEN, S32_MIN, S32_MIN, 12, S32_MAX, S32_MIN,
				1, 0),
			no_res});
		// unit bands right on the limit edges
		plan.push_back({16'sd1, 1'b0,
			sample_of(2'd0, jlg_pkg::MODE_POS, 100, 100, 13, 100, -100, 1, 0), no_res});
		plan.push_back({16'sd1, 1'b0,
			sample_of(2'd0, jlg_pkg::MODE_OPEN, -100, -100, 13, 100, -100, 1, 0), no_res});
		plan.push_back({-16'sd1, 1'b0,
			sample_of(2'd1, jlg_pkg::MODE_POS, 101, 100, 14, 100, -100, 1, 0), no_res});
		plan.push_back({-16'sd1, 1'b0,
			sample_of(2'd1, jlg_pkg::MODE_POS, -101, -101, 14, 100, -100, 1, 0), no_res});

		foreach (plan[i]) begin
			if (plan[i].band != band_now) begin
				settle_block();
				write_band(plan[i].band);
			end
			offer_sample(plan[i].stim, idle_len(), plan[i].known, plan[i].want);
		end

		// random phases, one band setting each, extremes first
		band_plan[0] = BAND_MAX;
		band_plan[1] = BAND_MIN;
		band_plan[2] = 16'sd0;
		band_plan[3] = 16'sd1;
		band_plan[4] = -16'sd1;
		band_plan[5] = 16'($urandom());
		band_plan[6] = 16'sd200;
		band_plan[7] = -16'sd200;
		band_plan[8] = 16'($urandom());
		band_plan[9] = 16'sd0;
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_block();
			write_band(band_plan[ph]);
			tx_eager = (ph == 2) || (ph == 6);
			rx_eager = (ph == 4);
			// consumer stalls for a long stretch while samples keep coming
			if (ph == 2)
				hold_ask++;
			for (int k = 0; k < PHASE_SAMPLES; k++) begin
				// producer waits out every owed result halfway through
				if (ph == 5 && k == PHASE_SAMPLES / 2)
					settle_block();
				offer_sample(rand_sample(band_now), tx_eager ? 0 : idle_len(), 1'b0,
					no_res);
			end
		end

		settle_block();
		// a few more cycles to catch any stray beat
		repeat (8) @(posedge clk);
		if (faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
